// ===== hw/rtl/chacha_pkg.sv =====
// ----------------------------------------------------------------------------
// ChaCha package
// Shared types, round count, state constants, register codes and the
// sequencer states of the ChaCha stream cipher.
// ----------------------------------------------------------------------------
package chacha_pkg;

    // Number of rounds; the round loop runs in pairs (column and diagonal).
    localparam int ROUND_COUNT   = 20;
    localparam int DOUBLE_ROUNDS = (ROUND_COUNT + 1) / 2;
    localparam int DR_W          = (DOUBLE_ROUNDS > 1) ? $clog2(DOUBLE_ROUNDS) : 1;

    typedef logic [31:0]       word_t;
    typedef logic [15:0][31:0] block_t;

    // Constant words: "expand 32-byte k" (sigma) and "expand 16-byte k" (tau).
    localparam word_t CONST_WORD0 = 32'h6170_7865;
    localparam word_t SIGMA_WORD1 = 32'h3320_646e;
    localparam word_t SIGMA_WORD2 = 32'h7962_2d32;
    localparam word_t TAU_WORD1   = 32'h3120_646e;
    localparam word_t TAU_WORD2   = 32'h7962_2d36;
    localparam word_t CONST_WORD3 = 32'h6b20_6574;

    // Configuration register indexes.
    typedef logic [2:0] cfg_index_t;
    localparam cfg_index_t CFG_KEY_PART_0 = 3'd0;
    localparam cfg_index_t CFG_KEY_PART_1 = 3'd1;
    localparam cfg_index_t CFG_KEY_PART_2 = 3'd2;
    localparam cfg_index_t CFG_KEY_PART_3 = 3'd3;
    localparam cfg_index_t CFG_KEY_IS_256 = 3'd4;
    localparam cfg_index_t CFG_NONCE      = 3'd5;

    // Top-level item sequencer.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_GEN,
        ST_EMIT
    } top_state_t;

    // Block generator sequencer.
    typedef enum logic [1:0] {
        CORE_IDLE,
        CORE_ROUND,
        CORE_ADD
    } core_state_t;

endpackage

// ===== hw/rtl/chacha_round_unit.sv =====
// ----------------------------------------------------------------------------
// ChaCha round unit
// One add-xor-rotate step of four parallel quarter rounds, on column or
// diagonal lanes of the 16-word state.
// ----------------------------------------------------------------------------
module chacha_round_unit (
    input  chacha_pkg::block_t words_in,
    input  logic               diag,
    input  logic [1:0]         step,
    output chacha_pkg::block_t words_out
);
    import chacha_pkg::*;

    logic [1:0] lane;
    logic [3:0] x_idx;
    logic [3:0] y_idx;
    logic [3:0] z_idx;
    word_t      sum;
    word_t      mix;
    word_t      rot;

    // Word index of a lane in a given row; diagonal rounds shift the column by the row.
    function automatic logic [3:0] lane_index(input logic [1:0] ln, input logic dg,
                                              input logic [1:0] row);
        logic [1:0] col;
        col = ln + (dg ? row : 2'd0);
        return {row, col};
    endfunction

    // Even steps add b into a and rotate d; odd steps add d into c and rotate b.
    always_comb
    begin
        words_out = words_in;
        lane  = 2'd0;
        x_idx = 4'd0;
        y_idx = 4'd0;
        z_idx = 4'd0;
        sum   = '0;
        mix   = '0;
        rot   = '0;
        for (int i = 0; i < 4; i++)
        begin
            lane  = 2'(i);
            x_idx = lane_index(lane, diag, step[0] ? 2'd2 : 2'd0);
            y_idx = lane_index(lane, diag, step[0] ? 2'd3 : 2'd1);
            z_idx = lane_index(lane, diag, step[0] ? 2'd1 : 2'd3);
            sum   = words_in[x_idx] + words_in[y_idx];
            mix   = words_in[z_idx] ^ sum;
            case (step)
                2'd0:    rot = {mix[15:0], mix[31:16]};
                2'd1:    rot = {mix[19:0], mix[31:20]};
                2'd2:    rot = {mix[23:0], mix[31:24]};
                default: rot = {mix[24:0], mix[31:25]};
            endcase
            words_out[x_idx] = sum;
            words_out[z_idx] = rot;
        end
    end

endmodule

// ===== hw/rtl/chacha_core.sv =====
// ----------------------------------------------------------------------------
// ChaCha block generator
// Runs the rounds on the loaded state through the shared round unit, one
// step per cycle, then adds the input words to leave the keystream block.
// ----------------------------------------------------------------------------
module chacha_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  chacha_pkg::block_t init_words,
    output logic               done,
    output chacha_pkg::block_t words
);
    import chacha_pkg::*;

    core_state_t     state_reg;
    core_state_t     state_next;
    logic [2:0]      step_reg;
    logic [2:0]      step_next;
    logic [DR_W-1:0] round_reg;
    logic [DR_W-1:0] round_next;
    block_t          words_reg;
    block_t          words_next;
    block_t          unit_out;

    // Step bit 2 selects diagonal lanes, bits 1:0 the quarter-round step.
    chacha_round_unit u_round (
        .words_in  (words_reg),
        .diag      (step_reg[2]),
        .step      (step_reg[1:0]),
        .words_out (unit_out)
    );

    // Sequencer state and counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CORE_IDLE;
            step_reg  <= 3'd0;
            round_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            round_reg <= round_next;
        end
    end

    // Working state; after the final add it holds the keystream block.
    always_ff @(posedge clk)
    begin
        words_reg <= words_next;
    end

    // Next state: load, eight steps per double round, then the final add.
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        round_next = round_reg;
        words_next = words_reg;
        done       = 1'b0;
        unique case (state_reg)
            CORE_IDLE:
            begin
                if (start)
                begin
                    words_next = init_words;
                    step_next  = 3'd0;
                    round_next = '0;
                    state_next = CORE_ROUND;
                end
            end
            CORE_ROUND:
            begin
                words_next = unit_out;
                step_next  = step_reg + 3'd1;
                if (step_reg == 3'd7)
                begin
                    round_next = round_reg + 1'b1;
                    if (round_reg == DR_W'(DOUBLE_ROUNDS - 1))
                    begin
                        state_next = CORE_ADD;
                    end
                end
            end
            CORE_ADD:
            begin
                for (int i = 0; i < 16; i++)
                begin
                    words_next[i] = words_reg[i] + init_words[i];
                end
                done       = 1'b1;
                state_next = CORE_IDLE;
            end
            default:
            begin
                state_next = CORE_IDLE;
            end
        endcase
    end

    assign words = words_reg;

endmodule

// ===== hw/rtl/chacha_stream_cipher.sv =====
// ----------------------------------------------------------------------------
// ChaCha stream cipher
// Encrypts 8-byte message items with ChaCha keystream, generating a new
// 64-byte block at the first item of each block.
// ----------------------------------------------------------------------------
// Timing: an item that starts a block waits in ST_GEN for the rounds and the
// final add of the block generator, then its result is registered from ST_EMIT;
// any other item goes straight to ST_EMIT. One item at a time: a new item is
// stalled until the last one has left ST_EMIT.
// Reset clears the sequencers, counter, chunk position, key and nonce registers
// and the result valid flag; the 256-bit key mode is selected after reset.
module chacha_stream_cipher (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   chunk_valid,
    output logic                   chunk_stall,
    input  logic [63:0]            message_chunk,
    input  logic [3:0]             valid_bytes,
    input  logic                   end_of_message,
    input  logic                   raw_keystream,
    output logic                   result_valid,
    input  logic                   result_stall,
    output logic [63:0]            result_chunk,
    output logic [3:0]             result_bytes,
    output logic                   result_last,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  chacha_pkg::cfg_index_t cfg_index,
    input  logic [63:0]            cfg_data
);
    import chacha_pkg::*;

    top_state_t  state_reg;
    top_state_t  state_next;
    logic [63:0] key0_reg;
    logic [63:0] key1_reg;
    logic [63:0] key2_reg;
    logic [63:0] key3_reg;
    logic        wide_reg;
    logic [63:0] nonce_reg;
    logic [63:0] counter_reg;
    logic [2:0]  pos_reg;
    logic [63:0] msg_reg;
    logic [3:0]  nbytes_reg;
    logic        last_reg;
    logic        ksonly_reg;
    logic        res_valid_reg;
    logic [63:0] res_chunk_reg;
    logic [3:0]  res_bytes_reg;
    logic        res_last_reg;

    logic        accept;
    logic        cfg_write;
    logic        emit;
    logic        core_start;
    logic        core_done;
    block_t      init_words;
    block_t      ks_words;
    logic [63:0] ks;
    logic [63:0] byte_mask;
    logic [63:0] res_value;
    logic [63:0] k2;
    logic [63:0] k3;

    assign accept      = chunk_valid && !chunk_stall;
    assign chunk_stall = (state_reg != ST_IDLE);
    assign cfg_ready   = 1'b1;
    assign cfg_write   = cfg_valid && cfg_ready;
    assign core_start  = accept && (pos_reg == 3'd0);
    assign emit        = (state_reg == ST_EMIT) && (!res_valid_reg || !result_stall);

    // Initial state words from constants, key, counter and nonce.
    assign k2 = wide_reg ? key2_reg : key0_reg;
    assign k3 = wide_reg ? key3_reg : key1_reg;
    always_comb
    begin
        init_words[0]  = CONST_WORD0;
        init_words[1]  = wide_reg ? SIGMA_WORD1 : TAU_WORD1;
        init_words[2]  = wide_reg ? SIGMA_WORD2 : TAU_WORD2;
        init_words[3]  = CONST_WORD3;
        init_words[4]  = key0_reg[31:0];
        init_words[5]  = key0_reg[63:32];
        init_words[6]  = key1_reg[31:0];
        init_words[7]  = key1_reg[63:32];
        init_words[8]  = k2[31:0];
        init_words[9]  = k2[63:32];
        init_words[10] = k3[31:0];
        init_words[11] = k3[63:32];
        init_words[12] = counter_reg[31:0];
        init_words[13] = counter_reg[63:32];
        init_words[14] = nonce_reg[31:0];
        init_words[15] = nonce_reg[63:32];
    end

    chacha_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (core_start),
        .init_words (init_words),
        .done       (core_done),
        .words      (ks_words)
    );

    // Keystream slot for this item, byte mask and the result value.
    assign ks = {ks_words[{pos_reg, 1'b1}], ks_words[{pos_reg, 1'b0}]};
    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            byte_mask[8*i +: 8] = (4'(i) < nbytes_reg) ? 8'hFF : 8'h00;
        end
    end
    assign res_value = (ksonly_reg ? ks : (ks ^ msg_reg)) & byte_mask;

    // Item sequencer state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state: wait for block generation when needed, then emit the result.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (pos_reg == 3'd0) ? ST_GEN : ST_EMIT;
                end
            end
            ST_GEN:
            begin
                if (core_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (emit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Configuration registers, block counter and chunk position.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key0_reg    <= '0;
            key1_reg    <= '0;
            key2_reg    <= '0;
            key3_reg    <= '0;
            wide_reg    <= 1'b1;
            nonce_reg   <= '0;
            counter_reg <= '0;
            pos_reg     <= 3'd0;
        end
        else
        begin
            if (core_done)
            begin
                counter_reg <= counter_reg + 64'd1;
            end
            if (emit)
            begin
                pos_reg <= last_reg ? 3'd0 : pos_reg + 3'd1;
            end
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_KEY_PART_0: key0_reg <= cfg_data;
                    CFG_KEY_PART_1: key1_reg <= cfg_data;
                    CFG_KEY_PART_2: key2_reg <= cfg_data;
                    CFG_KEY_PART_3: key3_reg <= cfg_data;
                    CFG_KEY_IS_256: wide_reg <= cfg_data[0];
                    CFG_NONCE:
                    begin
                        nonce_reg   <= cfg_data;
                        counter_reg <= '0;
                        pos_reg     <= 3'd0;
                    end
                    default: ;
                endcase
            end
        end
    end

    // Accepted item fields.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            msg_reg    <= message_chunk;
            nbytes_reg <= valid_bytes;
            last_reg   <= end_of_message;
            ksonly_reg <= raw_keystream;
        end
    end

    // Output register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            res_chunk_reg <= res_value;
            res_bytes_reg <= nbytes_reg;
            res_last_reg  <= last_reg;
        end
    end

    assign result_valid = res_valid_reg;
    assign result_chunk = res_chunk_reg;
    assign result_bytes = res_bytes_reg;
    assign result_last  = res_last_reg;

endmodule
